>>> rtl/mwas_pkg.sv
// Package for the maximum-weight assignment search block.
// Holds the word layouts, field widths and register map constants.
// No dependencies; compiled before the interface and every module.
`default_nettype none

package mwas_pkg;

  localparam int CHILD_W    = 3;
  localparam int TOY_W      = 4;
  localparam int SCORE_W    = 16;
  localparam int TOTAL_W    = 19;
  localparam int CFG_TOYS_W = 5;
  localparam int CFG_KIDS_W = 4;
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;

  // Registers sit at 4-byte spacing, so one address bit selects them.
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_NUM_TOYS     = 1'b0;
  localparam logic REG_NUM_CHILDREN = 1'b1;

  localparam logic [CFG_TOYS_W-1:0] NUM_TOYS_RST     = 5'd16;
  localparam logic [CFG_KIDS_W-1:0] NUM_CHILDREN_RST = 4'd8;

  typedef struct packed {
    logic [CHILD_W-1:0]        child;
    logic [TOY_W-1:0]          toy;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] best_total;
    logic                      no_assignment;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/mwas_stream_if.sv
// Valid/ready stream interface used by both channels of the search block.
// The word type is a parameter; the block uses the structs of mwas_pkg.
`default_nettype none

interface mwas_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mwas_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the score matrix of the search block.
`default_nettype none

module mwas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/max_weight_assignment_search.sv
// Maximum-weight assignment search: top level.
// Depends on mwas_pkg, mwas_stream_if and mwas_ram.
//
// Usage: each word on in_ch writes one entry (child, toy, score) of the score
// matrix, one word per cycle when idle. Entries with an index beyond the store
// are dropped. A word with last set also starts a search; in_ch.ready stays low
// until the search has finished and its result is in the output register.
// The search first sweeps the used rows bottom-up to build suffix sums of
// each row's maximum (clamped at zero), all through the single read port of
// the score RAM. It then runs a depth-first branch and bound: a candidate toy
// already taken is skipped, one tried is read from the RAM, then added and
// compared, and a backtrack is one scan step, so the latency grows with the
// number of nodes visited. Searches with no children or fewer toys than
// children go straight to S_DONE. One result word appears on out_ch per
// search; it is held in an output register until taken, and loading may
// resume while it waits. A second search finishing while that word still
// waits holds its result. The user must write num_toys and num_children over
// the APB-style port only while the block is idle; the block does not enforce
// it. Reset restores 16 toys and 8 children and clears all control state; the
// score RAM keeps no reset value and must be written before it is read.
`default_nettype none

module max_weight_assignment_search #(
  parameter int MAX_CHILDREN = 8,
  parameter int MAX_TOYS     = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  mwas_stream_if.sink                       in_ch,
  mwas_stream_if.source                     out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwas_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mwas_pkg::PDATA_W-1:0] pwdata,
  output      logic [mwas_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready
);

  import mwas_pkg::*;

  localparam int CW  = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int TW  = (MAX_TOYS > 1) ? $clog2(MAX_TOYS) : 1;
  localparam int LW  = $clog2(MAX_CHILDREN + 1);
  localparam int TCW = $clog2(MAX_TOYS + 1);
  localparam int SW  = SCORE_W + CW + 1;
  localparam int SW1 = SW + 1;
  localparam int AW  = CW + TW;
  localparam int RAM_DEPTH = 1 << AW;

  typedef enum logic [2:0] {S_IDLE, S_PEAK, S_SCAN, S_EVAL, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [CFG_TOYS_W-1:0] num_toys_r, num_toys_nxt;
  logic [CFG_KIDS_W-1:0] num_children_r, num_children_nxt;

  // Bound sweep: issue side and data side of the RAM read.
  logic [CW-1:0]             pk_row_r, pk_row_nxt;
  logic [TW-1:0]             pk_col_r, pk_col_nxt;
  logic                      iss_r, iss_nxt;
  logic                      dv_r, dv_nxt;
  logic [CW-1:0]             drow_r, drow_nxt;
  logic                      dlast_r, dlast_nxt;
  logic signed [SCORE_W-1:0] peak_r, peak_nxt;
  logic signed [SW-1:0]      acc_r, acc_nxt;

  // Search stack and status.
  logic signed [SW-1:0] bnd_r [MAX_CHILDREN];
  logic signed [SW-1:0] bnd_nxt [MAX_CHILDREN];
  logic signed [SW-1:0] ps_r [MAX_CHILDREN];
  logic signed [SW-1:0] ps_nxt [MAX_CHILDREN];
  logic [TW-1:0]        chosen_r [MAX_CHILDREN];
  logic [TW-1:0]        chosen_nxt [MAX_CHILDREN];
  logic [LW-1:0]        lvl_r, lvl_nxt;
  logic [TCW-1:0]       t_r, t_nxt;
  logic [MAX_TOYS-1:0]  taken_r, taken_nxt;
  logic signed [SW-1:0] best_r, best_nxt;
  logic                 best_ok_r, best_ok_nxt;

  logic signed [SW-1:0] res_total_r, res_total_nxt;
  logic                 res_none_r, res_none_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic [LW-1:0]             rows;
  logic [TCW-1:0]            cols;
  logic                      in_fire;
  logic                      in_range;
  logic                      cfg_wr;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [SCORE_W-1:0]        ram_rdata;
  logic signed [SCORE_W-1:0] rdata_s;
  logic signed [SCORE_W-1:0] pk_max;
  logic signed [SW-1:0]      pk_acc;
  logic [LW-1:0]             lvl_inc;
  logic [LW-1:0]             lvl_dec;
  logic signed [SW-1:0]      sum;
  logic signed [SW1-1:0]     bound_sum;
  logic                      pk_col_end;

  // Register values above the store size fall back to the store size.
  assign rows = (int'(num_children_r) > MAX_CHILDREN) ? LW'(MAX_CHILDREN)
                                                      : LW'(num_children_r);
  assign cols = (int'(num_toys_r) > MAX_TOYS) ? TCW'(MAX_TOYS) : TCW'(num_toys_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = (int'(in_ch.data.child) < MAX_CHILDREN) &&
                       (int'(in_ch.data.toy) < MAX_TOYS);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[REG_IDX_LSB] == REG_NUM_CHILDREN) ? PDATA_W'(num_children_r)
                                                           : PDATA_W'(num_toys_r);

  assign ram_we    = in_fire && in_range;
  assign ram_waddr = {CW'(in_ch.data.child), TW'(in_ch.data.toy)};

  mwas_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (RAM_DEPTH)
  ) u_score_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.data.score),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rdata_s    = ram_rdata;
  assign pk_max     = (rdata_s > peak_r) ? rdata_s : peak_r;
  assign pk_acc     = acc_r + SW'(pk_max);
  assign pk_col_end = (pk_col_r == TW'(cols - TCW'(1)));
  assign lvl_inc    = lvl_r + LW'(1);
  assign lvl_dec    = lvl_r - LW'(1);
  assign sum        = ps_r[lvl_r[CW-1:0]] + SW'(rdata_s);
  assign bound_sum  = SW1'(sum) + SW1'(bnd_r[lvl_inc[CW-1:0]]);

  always_comb begin
    state_nxt        = state_r;
    num_toys_nxt     = num_toys_r;
    num_children_nxt = num_children_r;
    pk_row_nxt       = pk_row_r;
    pk_col_nxt       = pk_col_r;
    iss_nxt          = iss_r;
    dv_nxt           = 1'b0;
    drow_nxt         = pk_row_r;
    dlast_nxt        = pk_col_end;
    peak_nxt         = peak_r;
    acc_nxt          = acc_r;
    bnd_nxt          = bnd_r;
    ps_nxt           = ps_r;
    chosen_nxt       = chosen_r;
    lvl_nxt          = lvl_r;
    t_nxt            = t_r;
    taken_nxt        = taken_r;
    best_nxt         = best_r;
    best_ok_nxt      = best_ok_r;
    res_total_nxt    = res_total_r;
    res_none_nxt     = res_none_r;
    out_valid_nxt    = out_valid_r;
    out_word_nxt     = out_word_r;
    ram_re           = 1'b0;
    ram_raddr        = {lvl_r[CW-1:0], t_r[TW-1:0]};

    if (cfg_wr) begin
      unique case (paddr[REG_IDX_LSB])
        REG_NUM_TOYS:     num_toys_nxt     = pwdata[CFG_TOYS_W-1:0];
        REG_NUM_CHILDREN: num_children_nxt = pwdata[CFG_KIDS_W-1:0];
        default:          num_toys_nxt     = num_toys_r;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.data.last) begin
          if (rows == '0) begin
            res_total_nxt = '0;
            res_none_nxt  = 1'b0;
            state_nxt     = S_DONE;
          end else if (int'(cols) < int'(rows)) begin
            res_total_nxt = '1;
            res_none_nxt  = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            pk_row_nxt = CW'(rows - LW'(1));
            pk_col_nxt = '0;
            iss_nxt    = 1'b1;
            peak_nxt   = '0;
            acc_nxt    = '0;
            state_nxt  = S_PEAK;
          end
        end
      end

      S_PEAK: begin
        // Reads are issued one per cycle from the bottom row up; the registered
        // read data is folded into the row maximum.
        if (iss_r) begin
          ram_re    = 1'b1;
          ram_raddr = {pk_row_r, pk_col_r};
          dv_nxt    = 1'b1;
          if (pk_col_end) begin
            pk_col_nxt = '0;
            if (pk_row_r == '0) begin
              iss_nxt = 1'b0;
            end else begin
              pk_row_nxt = pk_row_r - CW'(1);
            end
          end else begin
            pk_col_nxt = pk_col_r + TW'(1);
          end
        end
        if (dv_r) begin
          if (dlast_r) begin
            bnd_nxt[drow_r] = pk_acc;
            acc_nxt         = pk_acc;
            peak_nxt        = '0;
            if (drow_r == '0) begin
              lvl_nxt     = '0;
              t_nxt       = '0;
              taken_nxt   = '0;
              ps_nxt[0]   = '0;
              best_nxt    = '1;
              best_ok_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
          end else begin
            peak_nxt = pk_max;
          end
        end
      end

      S_SCAN: begin
        if (t_r == cols) begin
          if (lvl_r == '0) begin
            res_total_nxt = best_ok_r ? best_r : '1;
            res_none_nxt  = !best_ok_r;
            state_nxt     = S_DONE;
          end else begin
            // Backtrack: free the parent's toy and move to its next one.
            lvl_nxt = lvl_dec;
            taken_nxt[chosen_r[lvl_dec[CW-1:0]]] = 1'b0;
            t_nxt = TCW'(chosen_r[lvl_dec[CW-1:0]]) + TCW'(1);
          end
        end else if (taken_r[t_r[TW-1:0]]) begin
          t_nxt = t_r + TCW'(1);
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        state_nxt = S_SCAN;
        if (lvl_inc == rows) begin
          if (!best_ok_r || (sum > best_r)) begin
            best_nxt    = sum;
            best_ok_nxt = 1'b1;
          end
          t_nxt = t_r + TCW'(1);
        end else if (!best_ok_r || (bound_sum > SW1'(best_r))) begin
          taken_nxt[t_r[TW-1:0]]          = 1'b1;
          chosen_nxt[lvl_r[CW-1:0]]       = t_r[TW-1:0];
          ps_nxt[lvl_inc[CW-1:0]]         = sum;
          lvl_nxt                         = lvl_inc;
          t_nxt                           = '0;
        end else begin
          t_nxt = t_r + TCW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.best_total    = TOTAL_W'(res_total_r);
          out_word_nxt.no_assignment = res_none_r;
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    drow_r      <= drow_nxt;
    dlast_r     <= dlast_nxt;
    peak_r      <= peak_nxt;
    acc_r       <= acc_nxt;
    bnd_r       <= bnd_nxt;
    ps_r        <= ps_nxt;
    chosen_r    <= chosen_nxt;
    best_r      <= best_nxt;
    res_total_r <= res_total_nxt;
    res_none_r  <= res_none_nxt;
    out_word_r  <= out_word_nxt;
    pk_row_r    <= pk_row_nxt;
    pk_col_r    <= pk_col_nxt;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      num_toys_r     <= NUM_TOYS_RST;
      num_children_r <= NUM_CHILDREN_RST;
      iss_r          <= 1'b0;
      dv_r           <= 1'b0;
      lvl_r          <= '0;
      t_r            <= '0;
      taken_r        <= '0;
      best_ok_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      num_toys_r     <= num_toys_nxt;
      num_children_r <= num_children_nxt;
      iss_r          <= iss_nxt;
      dv_r           <= dv_nxt;
      lvl_r          <= lvl_nxt;
      t_r            <= t_nxt;
      taken_r        <= taken_nxt;
      best_ok_r      <= best_ok_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // The search never climbs past the last used row.
  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EVAL) |-> (lvl_r < rows))
    else $error("search level beyond the used rows");

  // Exactly one toy is held for each level above the current one.
  a_taken_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EVAL) |-> ($countones(taken_r) == int'(lvl_r)))
    else $error("taken toy mask out of step with search level");

  // A word flagged as no assignment always carries a total of minus one.
  a_none_means_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.no_assignment) |-> (out_word_r.best_total == '1))
    else $error("no-assignment word with a total other than minus one");

endmodule

`default_nettype wire

>>> dv/max_weight_assignment_search_tb.sv
`timescale 1ns / 100ps
// Testbench for max_weight_assignment_search: loads score matrices, starts searches and
// checks each best total against a branch-and-bound predictor kept in the bench.
// Depends on mwas_pkg, mwas_stream_if and the block's top level from the RTL.

module max_weight_assignment_search_tb;
  import mwas_pkg::*;

  localparam int ROWS = 8;
  localparam int COLS = 16;
  localparam int ITEM_TARGET = 1400;
  localparam int SCORE_MAX = 32767;
  localparam int SCORE_MIN = -32768;

  typedef enum int {FILL_RANDOM, FILL_NEGATIVE, FILL_NARROW, FILL_DIAGONAL} fill_kind_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_MOSTLY} sink_mode_t;

  class assignment_scoreboard;
    int              score_tab[ROWS][COLS];
    int              toys_reg;
    int              kids_reg;
    int              peak_sum[ROWS+1];
    int              path_sum[ROWS+1];
    logic [COLS-1:0] taken;
    int              best;
    bit              best_found;
    out_word_t       pending[$];
    int              errors;

    function new();
      toys_reg = NUM_TOYS_RST;
      kids_reg = NUM_CHILDREN_RST;
      errors = 0;
      foreach (score_tab[r, k]) score_tab[r][k] = 0;
    endfunction

    function void set_register(logic idx, int value);
      if (idx == REG_NUM_TOYS) begin
        toys_reg = value & ((1 << CFG_TOYS_W) - 1);
      end else begin
        kids_reg = value & ((1 << CFG_KIDS_W) - 1);
      end
    endfunction

    // Depth-first walk over distinct toys, cut off when the optimistic bound can't win.
    function void descend(int level, int rows, int cols);
      int sum;
      for (int t = 0; t < cols; t++) begin
        if (taken[t]) continue;
        taken[t] = 1'b1;
        sum = path_sum[level] + score_tab[level][t];
        path_sum[level+1] = sum;
        if (level + 1 == rows) begin
          if (!best_found || sum > best) begin
            best = sum;
            best_found = 1'b1;
          end
        end else if (!best_found || sum + peak_sum[level+1] > best) begin
          descend(level + 1, rows, cols);
        end
        taken[t] = 1'b0;
      end
    endfunction

    function out_word_t best_assignment(int rows, int cols);
      out_word_t res;
      int peak;
      peak_sum[rows] = 0;
      for (int r = rows; r > 0; r--) begin
        peak = 0;
        for (int k = 0; k < cols; k++)
          if (score_tab[r-1][k] > peak) peak = score_tab[r-1][k];
        peak_sum[r-1] = peak_sum[r] + peak;
      end
      taken = '0;
      path_sum[0] = 0;
      best = -1;
      best_found = 1'b0;
      res.no_assignment = 1'b0;
      if (rows == 0) begin
        res.best_total = '0;
      end else if (cols < rows) begin
        res.best_total = '1;
        res.no_assignment = 1'b1;
      end else begin
        descend(0, rows, cols);
        res.best_total = best_found ? TOTAL_W'(best) : '1;
        res.no_assignment = !best_found;
      end
      return res;
    endfunction

    // Child and toy fields are narrow enough that every word lands in the store.
    function void note_input(in_word_t w);
      int rows, cols;
      score_tab[w.child][w.toy] = $signed(w.score);
      if (w.last) begin
        rows = kids_reg > ROWS ? ROWS : kids_reg;
        cols = toys_reg > COLS ? COLS : toys_reg;
        pending = {pending, best_assignment(rows, cols)};
      end
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("result word with nothing pending: total %0d, none %0b",
                         $signed(got.best_total), got.no_assignment));
        return;
      end
      want = pending.pop_front();
      if (got.best_total !== want.best_total)
        report($sformatf("best_total %0d, expected %0d",
                         $signed(got.best_total), $signed(want.best_total)));
      if (got.no_assignment !== want.no_assignment)
        report($sformatf("no_assignment %0b, expected %0b",
                         got.no_assignment, want.no_assignment));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  mwas_stream_if #(.word_t(in_word_t))  in_ch ();
  mwas_stream_if #(.word_t(out_word_t)) out_ch ();

  assignment_scoreboard board = new();
  bit written[ROWS][COLS];
  int diag_peak[ROWS];
  int burst_left = 0;
  int items_sent = 0;

  max_weight_assignment_search dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  // The result side runs through stretches of steady, patchy and sparse acceptance.
  initial begin : result_sink
    sink_mode_t mode;
    int left;
    out_ch.ready = 1'b0;
    mode = SINK_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 120);
      end
      left--;
      case (mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
        SINK_SLOW:   out_ch.ready <= ($urandom_range(0, 7) == 0);
        default:     out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    written[w.child][w.toy] = 1'b1;
  endtask

  task automatic send_entry(int child, int toy, int score, bit last);
    in_word_t w;
    w.child = CHILD_W'(child);
    w.toy = TOY_W'(toy);
    w.score = SCORE_W'(score);
    w.last = last;
    send_word(w);
  endtask

  // Drops valid and waits until every pending result has been taken. The first edge lets
  // the monitor note a word accepted at the edge this task was entered on.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << REG_IDX_LSB;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
  endtask

  task automatic configure(int toys, int kids);
    settle();
    write_register(REG_NUM_TOYS, toys);
    write_register(REG_NUM_CHILDREN, kids);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic int pick_score(fill_kind_t kind, int r, int k);
    int v;
    case (kind)
      FILL_NEGATIVE: v = -int'($urandom_range(1, 32768));
      FILL_NARROW:   v = int'($urandom_range(0, 20)) - 10;
      FILL_DIAGONAL: begin
        // Off-diagonal scores never beat the diagonal, so the first leaf meets the bound.
        if (k == r) v = diag_peak[r];
        else v = int'($urandom_range(0, diag_peak[r] - SCORE_MIN)) + SCORE_MIN;
      end
      default: begin
        case ($urandom_range(0, 15))
          0:       v = SCORE_MAX;
          1:       v = SCORE_MIN;
          default: v = int'($urandom_range(0, 65535)) + SCORE_MIN;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_stray(bit last);
    send_entry($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
               int'($urandom_range(0, 65535)) + SCORE_MIN, last);
  endtask

  // Writes the used region of the matrix and closes with a word marked last. A partial
  // load leaves some already written entries as they were.
  task automatic load_and_search(int kids, int toys, fill_kind_t kind, bit partial, bit noisy);
    int rows, cols, r, k, pick;
    int cells[$];
    if (kids != board.kids_reg || toys != board.toys_reg) configure(toys, kids);
    rows = kids > ROWS ? ROWS : kids;
    cols = toys > COLS ? COLS : toys;
    if (kind == FILL_DIAGONAL)
      foreach (diag_peak[i])
        diag_peak[i] = ($urandom_range(0, 3) == 0) ? SCORE_MAX : $urandom_range(0, SCORE_MAX);
    for (r = 0; r < rows; r++)
      for (k = 0; k < cols; k++) cells = {cells, r * COLS + k};
    cells.shuffle();
    foreach (cells[i]) begin
      r = cells[i] / COLS;
      k = cells[i] % COLS;
      if (partial && written[r][k] && $urandom_range(0, 1) == 1) continue;
      if (noisy && $urandom_range(0, 7) == 0) send_stray(1'b0);
      send_entry(r, k, pick_score(kind, r, k), 1'b0);
    end
    if (cells.size() == 0 || (kind != FILL_DIAGONAL && $urandom_range(0, 3) == 0)) begin
      send_stray(1'b1);
    end else begin
      pick = cells[$urandom_range(0, cells.size() - 1)];
      r = pick / COLS;
      k = pick % COLS;
      send_entry(r, k, pick_score(kind, r, k), 1'b1);
    end
  endtask

  initial begin : stimulus
    int pick, kids, toys, cur_kids, cur_toys;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single cell at the score extremes, and a true total of -1 with an assignment.
    configure(1, 1);
    send_entry(0, 0, SCORE_MAX, 1'b1);
    send_entry(0, 0, SCORE_MIN, 1'b1);
    send_entry(0, 0, -1, 1'b1);
    // No toys at all, then no children at all.
    configure(0, 3);
    send_entry(ROWS - 1, COLS - 1, 0, 1'b1);
    configure(5, 0);
    send_entry(3, 9, -5, 1'b1);
    // Fewer toys than children.
    configure(1, 2);
    send_entry(1, 0, 7, 1'b0);
    send_entry(0, 0, 3, 1'b1);
    // The greedy first leaf loses to the crossed pairing; then a rewrite of the kept store.
    configure(2, 2);
    send_entry(0, 0, 10, 1'b0);
    send_entry(0, 1, 9, 1'b0);
    send_entry(1, 0, 10, 1'b0);
    send_entry(1, 1, 1, 1'b1);
    send_entry(1, 0, -20, 1'b1);

    cur_kids = 3;
    cur_toys = 4;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        kids = ($urandom_range(0, 1) == 1) ? ROWS : $urandom_range(5, 15);
        toys = $urandom_range(kids > ROWS ? ROWS : kids, 31);
        load_and_search(kids, toys, FILL_DIAGONAL, 1'b0, 1'b0);
      end else if (pick < 9) begin
        kids = $urandom_range(0, 15);
        if (kids == 0) toys = $urandom_range(0, 31);
        else toys = $urandom_range(0, (kids > 4 ? 4 : kids) - 1);
        load_and_search(kids, toys, FILL_RANDOM, 1'b1, 1'b1);
      end else if (pick < 15) begin
        load_and_search($urandom_range(1, 2), $urandom_range(9, 31),
                        fill_kind_t'($urandom_range(0, 2)), 1'b0, 1'b1);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          cur_kids = $urandom_range(1, 4);
          cur_toys = $urandom_range(1, 6);
        end
        load_and_search(cur_kids, cur_toys, fill_kind_t'($urandom_range(0, 2)),
                        $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
